// ===== sv/mkq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan queue package
// Shared types, codes and default sizes for the keypad scanner and its queue.
// ----------------------------------------------------------------------------
package mkq_pkg;

   // default matrix and queue geometry
   localparam int ROWS_DEF        = 4;
   localparam int COLS_DEF        = 4;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int ROW_LSB_DEF     = 0;
   localparam int COL_LSB_DEF     = 4;

   // fixed field widths
   localparam int FUNC_W  = 2;
   localparam int REQ_W   = 2;
   localparam int ADDR_W  = 7;
   localparam int BYTE_W  = 8;
   localparam int KEY_W   = 4;
   localparam int PHASE_W = 3;
   localparam int ENTRY_W = KEY_W + 1;

   // item function codes
   localparam logic [FUNC_W-1:0] FN_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FN_DONE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_POP  = 2'd2;

   // bus request codes
   localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

   typedef enum logic [PHASE_W-1:0] {
      PH_SETUP_NEED = 3'd0,
      PH_SETUP_PEND = 3'd1,
      PH_READ_NEED  = 3'd2,
      PH_READ_PEND  = 3'd3,
      PH_DONE       = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_SCAN = 2'd2,
      ST_OUT  = 2'd3
   } ctl_state_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic scan_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_start;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ===== sv/matrix_keypad_scan_event_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix keypad scanner with key event queue
// Scans a key matrix through an I/O expander and queues press/release events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per command; req_tuser selects service tick, bus
//            transaction finished, or pop one key event.
//   rsp_*  : exactly one result word per command, in order, carrying the
//            offered bus request, a popped event and the scan phase after it.
//   csr_*  : writes the expander bus address; csr_ready is always high.
//            Write only while no command is in flight.
// Sequencing: a command passes through accept, execute and result load; the
//   service tick that processes a finished row read also walks the columns
//   between execute and load, comparing each key and enqueueing changes.
//   Commands are handled one at a time; the next word is taken as soon as
//   the previous one has reached the result stage.
// Stall: the result register holds while rsp_tready is low; one further
//   command may be accepted and executed, then waits for the register.
// Reset: synchronous, active high; phase returns to setup needed, row 0,
//   all keys released, event queue empty, bus address 0.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_event_queue_top #(
   parameter int ROWS        = mkq_pkg::ROWS_DEF,
   parameter int COLS        = mkq_pkg::COLS_DEF,
   parameter int QUEUE_DEPTH = mkq_pkg::QUEUE_DEPTH_DEF,
   parameter int ROW_LSB     = mkq_pkg::ROW_LSB_DEF,
   parameter int COL_LSB     = mkq_pkg::COL_LSB_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // bus_accept[0], bus_ok[1], read_data[9:2], zero[15:10]
   input  logic [1:0]  req_tuser,   // func[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // bus_address[6:0], write_byte[14:7], key_valid[15],
                                    // key_index[19:16], key_pressed[20], scan_phase[23:21]
   output logic [1:0]  rsp_tuser,   // request[1:0]
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // device_address[6:0]
);
   import mkq_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic [REQ_W-1:0]    rsp_request;
   logic [ADDR_W-1:0]   rsp_bus_address;
   logic [BYTE_W-1:0]   rsp_write_byte;
   logic                rsp_key_valid;
   logic [KEY_W-1:0]    rsp_key_index;
   logic                rsp_key_pressed;
   logic [PHASE_W-1:0]  rsp_scan_phase;

   // address register is always writable
   assign csr_ready = 1'b1;

   mkq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mkq_dp #(
      .ROWS        (ROWS),
      .COLS        (COLS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ROW_LSB     (ROW_LSB),
      .COL_LSB     (COL_LSB)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .item_func       (req_tuser),
      .item_bus_accept (req_tdata[0]),
      .item_bus_ok     (req_tdata[1]),
      .item_read_data  (req_tdata[9:2]),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_request     (rsp_request),
      .rsp_bus_address (rsp_bus_address),
      .rsp_write_byte  (rsp_write_byte),
      .rsp_key_valid   (rsp_key_valid),
      .rsp_key_index   (rsp_key_index),
      .rsp_key_pressed (rsp_key_pressed),
      .rsp_scan_phase  (rsp_scan_phase)
   );

   // pack result fields, lowest first
   assign rsp_tuser = rsp_request;
   assign rsp_tdata = {rsp_scan_phase, rsp_key_pressed, rsp_key_index,
                       rsp_key_valid, rsp_write_byte, rsp_bus_address};

endmodule

// ===== sv/mkq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan queue controller
// Sequences each word through decode, an optional scan and result hand-off.
// ----------------------------------------------------------------------------
module mkq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  mkq_pkg::status_type status,
   output mkq_pkg::cmd_type    cmd
);
   import mkq_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.scan_start ? ST_SCAN : ST_OUT;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the result register to drain
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.exec, cmd.scan_step, cmd.out_load}))
      else $error("more than one datapath command active");

   a_load_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> cmd.exec)
      else $error("accepted word not executed next cycle");

   a_out_then_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> req_tready)
      else $error("controller not idle after result hand-off");
`endif

endmodule

// ===== sv/mkq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan queue datapath
// Scan phase, key state, event queue memory and result register.
// ----------------------------------------------------------------------------
module mkq_dp #(
   parameter int ROWS        = mkq_pkg::ROWS_DEF,
   parameter int COLS        = mkq_pkg::COLS_DEF,
   parameter int QUEUE_DEPTH = mkq_pkg::QUEUE_DEPTH_DEF,
   parameter int ROW_LSB     = mkq_pkg::ROW_LSB_DEF,
   parameter int COL_LSB     = mkq_pkg::COL_LSB_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mkq_pkg::cmd_type             cmd,
   output mkq_pkg::status_type          status,
   input  logic [mkq_pkg::FUNC_W-1:0]   item_func,
   input  logic                         item_bus_accept,
   input  logic                         item_bus_ok,
   input  logic [mkq_pkg::BYTE_W-1:0]   item_read_data,
   input  logic                         csr_valid,
   input  logic [mkq_pkg::ADDR_W-1:0]   csr_data,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [mkq_pkg::REQ_W-1:0]    rsp_request,
   output logic [mkq_pkg::ADDR_W-1:0]   rsp_bus_address,
   output logic [mkq_pkg::BYTE_W-1:0]   rsp_write_byte,
   output logic                         rsp_key_valid,
   output logic [mkq_pkg::KEY_W-1:0]    rsp_key_index,
   output logic                         rsp_key_pressed,
   output logic [mkq_pkg::PHASE_W-1:0]  rsp_scan_phase
);
   import mkq_pkg::*;

   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [BYTE_W-1:0] ROW_MASK = BYTE_W'((1 << ROWS) - 1);
   localparam logic [BYTE_W-1:0] COL_MASK = BYTE_W'((1 << COLS) - 1);

   // captured input word
   logic [FUNC_W-1:0] func_ff;
   logic              bus_accept_ff;
   logic              bus_ok_ff;
   logic [BYTE_W-1:0] read_data_ff;

   // scan and queue state
   logic [ADDR_W-1:0] dev_addr_ff;
   phase_type         phase_ff, phase_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [BYTE_W-1:0] column_byte_ff, column_byte_in;
   logic [COLS-1:0]   key_down_ff [ROWS];
   logic [COLS-1:0]   key_down_in [ROWS];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // per-word result hold
   logic [REQ_W-1:0]  req_hold_ff, req_hold_in;
   logic [ADDR_W-1:0] addr_hold_ff, addr_hold_in;
   logic [BYTE_W-1:0] wbyte_hold_ff, wbyte_hold_in;
   logic              pop_hold_ff, pop_hold_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // queue memory
   logic [ENTRY_W-1:0] fifo_mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_en;
   logic               push_en;
   logic [ENTRY_W-1:0] push_entry;

   // scan helpers
   logic [BYTE_W-1:0]   row_bits;
   logic [BYTE_W-1:0]   drive_byte;
   logic [3:0]          col_pos;
   logic                col_low;
   logic [KEY_W-1:0]    key_idx;
   logic [PTR_W-1:0]    head_next;
   logic [PTR_W-1:0]    tail_next;

   assign row_bits   = ROW_MASK ^ (BYTE_W'(1) << row_ff);
   // bits shifted past the byte drop
   assign drive_byte = (row_bits << ROW_LSB) | (COL_MASK << COL_LSB);
   assign col_pos    = 4'(COL_LSB) + 4'(col_ff);
   // column lines beyond the byte read as low
   assign col_low    = col_pos[3] ? 1'b1 : ~column_byte_ff[col_pos[2:0]];
   assign key_idx    = KEY_W'(row_ff) * KEY_W'(COLS) + KEY_W'(col_ff);
   assign head_next  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign push_entry = {col_low, key_idx};

   always_comb begin
      phase_in       = phase_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      column_byte_in = column_byte_ff;
      key_down_in    = key_down_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      req_hold_in    = req_hold_ff;
      addr_hold_in   = addr_hold_ff;
      wbyte_hold_in  = wbyte_hold_ff;
      pop_hold_in    = pop_hold_ff;
      rsp_valid_in   = rsp_valid_ff;
      rd_en          = 1'b0;
      push_en        = 1'b0;
      status         = '0;

      if (cmd.exec) begin
         req_hold_in   = REQ_NONE;
         addr_hold_in  = '0;
         wbyte_hold_in = '0;
         pop_hold_in   = 1'b0;
         col_in        = '0;
         case (func_ff)
            FN_TICK: begin
               case (phase_ff)
                  PH_SETUP_NEED: begin
                     req_hold_in   = REQ_WRITE;
                     addr_hold_in  = dev_addr_ff;
                     wbyte_hold_in = drive_byte;
                     if (bus_accept_ff) begin
                        phase_in = PH_SETUP_PEND;
                     end
                  end
                  PH_READ_NEED: begin
                     req_hold_in  = REQ_READ;
                     addr_hold_in = dev_addr_ff;
                     if (bus_accept_ff) begin
                        phase_in = PH_READ_PEND;
                     end
                  end
                  PH_DONE: begin
                     status.scan_start = 1'b1;
                     phase_in          = PH_SETUP_NEED;
                  end
                  default: ;
               endcase
            end
            FN_DONE: begin
               case (phase_ff)
                  PH_SETUP_PEND: begin
                     phase_in = bus_ok_ff ? PH_READ_NEED : PH_SETUP_NEED;
                  end
                  PH_READ_PEND: begin
                     if (bus_ok_ff) begin
                        column_byte_in = read_data_ff;
                        phase_in       = PH_DONE;
                     end else begin
                        phase_in = PH_READ_NEED;
                     end
                  end
                  default: begin
                     phase_in = PH_SETUP_NEED;
                  end
               endcase
            end
            FN_POP: begin
               if (count_ff != '0) begin
                  rd_en       = 1'b1;
                  head_in     = head_next;
                  count_in    = count_ff - 1'b1;
                  pop_hold_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      status.scan_last = (col_ff == COL_W'(COLS - 1));

      if (cmd.scan_step) begin
         // queue a change only while there is room; otherwise retry next scan
         if ((key_down_ff[row_ff][col_ff] != col_low) && (count_ff < CNT_W'(QUEUE_DEPTH))) begin
            push_en                     = 1'b1;
            tail_in                     = tail_next;
            count_in                    = count_ff + 1'b1;
            key_down_in[row_ff][col_ff] = col_low;
         end
         if (status.scan_last) begin
            col_in = '0;
            row_in = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      status.out_free = ~rsp_valid_ff | rsp_tready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= '0;
         phase_ff       <= PH_SETUP_NEED;
         row_ff         <= '0;
         col_ff         <= '0;
         column_byte_ff <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         pop_hold_ff    <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            key_down_ff[r] <= '0;
         end
      end else begin
         if (csr_valid) begin
            dev_addr_ff <= csr_data;
         end
         phase_ff       <= phase_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         column_byte_ff <= column_byte_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         pop_hold_ff    <= pop_hold_in;
         key_down_ff    <= key_down_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff       <= item_func;
         bus_accept_ff <= item_bus_accept;
         bus_ok_ff     <= item_bus_ok;
         read_data_ff  <= item_read_data;
      end
      req_hold_ff   <= req_hold_in;
      addr_hold_ff  <= addr_hold_in;
      wbyte_hold_ff <= wbyte_hold_in;
      if (cmd.out_load) begin
         rsp_request     <= req_hold_ff;
         rsp_bus_address <= addr_hold_ff;
         rsp_write_byte  <= wbyte_hold_ff;
         rsp_key_valid   <= pop_hold_ff;
         rsp_key_index   <= pop_hold_ff ? rd_data_ff[KEY_W-1:0] : '0;
         rsp_key_pressed <= pop_hold_ff & rd_data_ff[KEY_W];
         rsp_scan_phase  <= phase_ff;
      end
   end

   // event queue memory
   always_ff @(posedge clock) begin
      if (push_en) begin
         fifo_mem[tail_ff] <= push_entry;
      end
      if (rd_en) begin
         rd_data_ff <= fifo_mem[head_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("event queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with unequal pointers");

   a_pop_no_request: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && pop_hold_in) |=> (req_hold_ff == REQ_NONE))
      else $error("pop word carries a bus request");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(QUEUE_DEPTH)) |-> !push_en)
      else $error("push into full event queue");
`endif

endmodule
